@@ hdl/dau_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dau_pkg
// Types, widths and helpers shared by the dihedral angle unit.
// ----------------------------------------------------------------------------
package dau_pkg;

    localparam int COORD_BITS   = 16;
    localparam int DIFF_W       = COORD_BITS + 1;
    localparam int VEC_W        = (DIFF_W > 31) ? 31 : DIFF_W;
    localparam int SH_MAX       = (DIFF_W > 30) ? DIFF_W - 30 : 0;
    localparam int SH_W         = $clog2(SH_MAX + 2);
    localparam int SQ_W         = 2 * VEC_W;
    localparam int ROOT_W       = VEC_W;
    localparam int UNIT_FRAC    = 14;
    localparam int QUO_W        = UNIT_FRAC + 1;
    localparam int NUM_W        = VEC_W + UNIT_FRAC + 1;
    localparam int UNIT_W       = 16;
    localparam int N_W          = 18;
    localparam int M_W          = 19;
    localparam int XY_W         = 40;
    localparam int CORDIC_W     = 44;
    localparam int ACC_W        = 26;
    localparam int ANG_W        = 17;
    localparam int ANG_MAX      = 46080;
    localparam int NORM_EXP     = 40;
    localparam int NORM_STAGES  = 6;
    localparam int ROUND_SHIFT  = 8;
    localparam int DEG90_Q16    = 90 * 65536;
    localparam int MAX_STEPS    = 32;
    localparam int CORDIC_STEPS_DEF = 16;

    // register counts: normaliser, geometry, CORDIC without its rotations
    localparam int NORM_LAT     = 4 + ROOT_W + QUO_W;
    localparam int GEOM_LAT     = 6;
    localparam int CORDIC_FIX_LAT = 3 + NORM_STAGES;

    typedef logic signed [COORD_BITS-1:0] t_coord;
    typedef logic signed [UNIT_W-1:0]     t_unit;
    typedef logic signed [XY_W-1:0]       t_xy;

    typedef struct packed {
        t_coord a_x;
        t_coord a_y;
        t_coord a_z;
        t_coord b_x;
        t_coord b_y;
        t_coord b_z;
        t_coord c_x;
        t_coord c_y;
        t_coord c_z;
        t_coord d_x;
        t_coord d_y;
        t_coord d_z;
    } t_item;

    typedef struct packed {
        logic signed [ANG_W-1:0] torsion_deg;
        logic                    degenerate;
    } t_result;

    // atan(2^-i) in degrees, Q.16
    localparam logic signed [ACC_W-1:0] ATAN_TAB [MAX_STEPS] = '{
        26'sd2949120, 26'sd1740967, 26'sd919879, 26'sd466945,
        26'sd234379,  26'sd117304,  26'sd58666,  26'sd29335,
        26'sd14668,   26'sd7334,    26'sd3667,   26'sd1833,
        26'sd917,     26'sd458,     26'sd229,    26'sd115,
        26'sd57,      26'sd29,      26'sd14,     26'sd7,
        26'sd4,       26'sd2,       26'sd1,      26'sd0,
        26'sd0,       26'sd0,       26'sd0,      26'sd0,
        26'sd0,       26'sd0,       26'sd0,      26'sd0
    };

    function automatic logic signed [ACC_W-1:0] atan_q16(input int i);
        return ATAN_TAB[5'(i)];
    endfunction

    // shift right, round half away from zero, k >= 1
    function automatic longint rshr(input longint v, input int k);
        longint half;
        half = longint'(1) <<< (k - 1);
        if (v >= 0) begin
            return (v + half) >>> k;
        end
        return -((-v + half) >>> k);
    endfunction

endpackage

@@ hdl/dau_norm.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dau_norm
// Bond vector p1 - p0 to a Q1.14 unit vector: squares, bit-per-stage
// square root, then a bit-per-stage divider on each component.
// ----------------------------------------------------------------------------
module dau_norm (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    input  dau_pkg::t_coord i_p0 [3],
    input  dau_pkg::t_coord i_p1 [3],
    output logic           o_valid,
    output dau_pkg::t_unit o_u [3],
    output logic           o_zero
);
    import dau_pkg::*;

    logic signed [DIFF_W-1:0] diff [3];
    logic [SH_W-1:0]          sh;
    logic signed [VEC_W-1:0]  n_w [3];
    logic                     n_zero;

    always_comb begin
        logic fit;
        for (int c = 0; c < 3; c++) begin
            diff[c] = $signed({i_p1[c][COORD_BITS-1], i_p1[c]})
                    - $signed({i_p0[c][COORD_BITS-1], i_p0[c]});
        end
        sh = '0;
        for (int s = SH_MAX; s >= 0; s--) begin
            fit = 1'b1;
            for (int c = 0; c < 3; c++) begin
                if (!((longint'(diff[c] >>> s) <  (longint'(1) <<< 30)) &&
                      (longint'(diff[c] >>> s) > -(longint'(1) <<< 30)))) begin
                    fit = 1'b0;
                end
            end
            if (fit) begin
                sh = SH_W'(s);
            end
        end
        n_zero = (diff[0] == '0) && (diff[1] == '0) && (diff[2] == '0);
        for (int c = 0; c < 3; c++) begin
            n_w[c] = VEC_W'(diff[c] >>> sh);
        end
    end

    // stage 1: scaled bond, stage 2: squares
    logic signed [VEC_W-1:0] r_w1 [3];
    logic signed [VEC_W-1:0] r_w2 [3];
    logic [SQ_W-1:0]         r_sq [3];
    logic                    r_z1, r_z2, r_v1, r_v2;

    // sqrt pipeline, entry 0 holds the sum of squares
    logic [SQ_W-1:0]         s_rem  [ROOT_W+1];
    logic [ROOT_W-1:0]       s_root [ROOT_W+1];
    logic signed [VEC_W-1:0] s_w    [ROOT_W+1][3];
    logic                    s_z    [ROOT_W+1];
    logic                    s_v    [ROOT_W+1];

    // divider pipeline, entry 0 holds the rounded numerators
    logic [NUM_W-1:0]        d_rem [QUO_W+1][3];
    logic [QUO_W-1:0]        d_q   [QUO_W+1][3];
    logic                    d_neg [QUO_W+1][3];
    logic [ROOT_W-1:0]       d_len [QUO_W+1];
    logic                    d_z   [QUO_W+1];
    logic                    d_v   [QUO_W+1];

    always_ff @(posedge i_clk) begin
        r_w1 <= n_w;
        r_z1 <= n_zero;
        for (int c = 0; c < 3; c++) begin
            r_sq[c] <= $unsigned(SQ_W'(r_w1[c]) * SQ_W'(r_w1[c]));
        end
        r_w2 <= r_w1;
        r_z2 <= r_z1;
        s_rem[0]  <= r_sq[0] + r_sq[1] + r_sq[2];
        s_root[0] <= '0;
        s_w[0]    <= r_w2;
        s_z[0]    <= r_z2;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1   <= 1'b0;
            r_v2   <= 1'b0;
            s_v[0] <= 1'b0;
            d_v[0] <= 1'b0;
        end else begin
            r_v1   <= i_valid;
            r_v2   <= r_v1;
            s_v[0] <= r_v2;
            d_v[0] <= s_v[ROOT_W];
        end
    end

    for (genvar g = 0; g < ROOT_W; g++) begin : g_sqrt
        localparam int J = ROOT_W - 1 - g;
        logic [SQ_W+1:0] trial;
        logic            take;
        assign trial = ((SQ_W + 2)'(s_root[g]) << (J + 1)) + ((SQ_W + 2)'(1) << (2 * J));
        assign take  = (SQ_W + 2)'(s_rem[g]) >= trial;
        always_ff @(posedge i_clk) begin
            s_rem[g+1]  <= take ? s_rem[g] - SQ_W'(trial) : s_rem[g];
            s_root[g+1] <= take ? (s_root[g] | (ROOT_W'(1) << J)) : s_root[g];
            s_w[g+1]    <= s_w[g];
            s_z[g+1]    <= s_z[g];
        end
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                s_v[g+1] <= 1'b0;
            end else begin
                s_v[g+1] <= s_v[g];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        logic [VEC_W-1:0] mag;
        for (int c = 0; c < 3; c++) begin
            mag = s_w[ROOT_W][c][VEC_W-1] ? VEC_W'(-s_w[ROOT_W][c]) : VEC_W'(s_w[ROOT_W][c]);
            d_rem[0][c] <= (NUM_W'(mag) << UNIT_FRAC) + NUM_W'(s_root[ROOT_W] >> 1);
            d_q[0][c]   <= '0;
            d_neg[0][c] <= s_w[ROOT_W][c][VEC_W-1];
        end
        d_len[0] <= s_root[ROOT_W];
        d_z[0]   <= s_z[ROOT_W];
    end

    for (genvar g = 0; g < QUO_W; g++) begin : g_div
        localparam int K = QUO_W - 1 - g;
        logic [NUM_W-1:0] dv;
        assign dv = NUM_W'(d_len[g]) << K;
        always_ff @(posedge i_clk) begin
            for (int c = 0; c < 3; c++) begin
                if (d_rem[g][c] >= dv) begin
                    d_rem[g+1][c] <= d_rem[g][c] - dv;
                    d_q[g+1][c]   <= d_q[g][c] | (QUO_W'(1) << K);
                end else begin
                    d_rem[g+1][c] <= d_rem[g][c];
                    d_q[g+1][c]   <= d_q[g][c];
                end
                d_neg[g+1][c] <= d_neg[g][c];
            end
            d_len[g+1] <= d_len[g];
            d_z[g+1]   <= d_z[g];
        end
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                d_v[g+1] <= 1'b0;
            end else begin
                d_v[g+1] <= d_v[g];
            end
        end
    end

    always_comb begin
        for (int c = 0; c < 3; c++) begin
            o_u[c] = d_neg[QUO_W][c] ? -UNIT_W'(d_q[QUO_W][c]) : UNIT_W'(d_q[QUO_W][c]);
        end
    end
    assign o_zero  = d_z[QUO_W];
    assign o_valid = d_v[QUO_W];

endmodule

@@ hdl/dau_geom.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dau_geom
// Cross products n1, n2, m = n1 x bc and the dot products x = n1.n2,
// y = m.n2; product stages alternate with difference and sum stages.
// ----------------------------------------------------------------------------
module dau_geom (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    input  dau_pkg::t_unit i_u0 [3],
    input  dau_pkg::t_unit i_u1 [3],
    input  dau_pkg::t_unit i_u2 [3],
    input  logic           i_degen,
    output logic           o_valid,
    output dau_pkg::t_xy   o_x,
    output dau_pkg::t_xy   o_y,
    output logic           o_degen
);
    import dau_pkg::*;

    localparam int PW1 = 2 * UNIT_W;
    localparam int PW2 = N_W + UNIT_W;
    localparam int XPW = 2 * N_W;
    localparam int YPW = M_W + N_W;

    logic signed [PW1-1:0] r_pa1 [3], r_pb1 [3], r_pa2 [3], r_pb2 [3];
    logic signed [PW2-1:0] r_ma [3], r_mb [3];
    logic signed [N_W-1:0] r_n1 [3], r_n2 [3], r_n1_3 [3], r_n2_3 [3];
    logic signed [N_W-1:0] r_n1_4 [3], r_n2_4 [3];
    logic signed [M_W-1:0] r_m [3];
    logic signed [XPW-1:0] r_xp [3];
    logic signed [YPW-1:0] r_yp [3];
    t_unit                 r_u1_1 [3], r_u1_2 [3];
    t_xy                   r_x, r_y;
    logic                  r_dg [6];
    logic                  r_v [6];

    for (genvar k = 0; k < 3; k++) begin : g_lane
        localparam int K1 = (k + 1) % 3;
        localparam int K2 = (k + 2) % 3;
        always_ff @(posedge i_clk) begin
            r_pa1[k]  <= PW1'(i_u0[K1]) * PW1'(i_u1[K2]);
            r_pb1[k]  <= PW1'(i_u0[K2]) * PW1'(i_u1[K1]);
            r_pa2[k]  <= PW1'(i_u1[K1]) * PW1'(i_u2[K2]);
            r_pb2[k]  <= PW1'(i_u1[K2]) * PW1'(i_u2[K1]);
            r_u1_1[k] <= i_u1[k];

            r_n1[k]   <= N_W'(rshr(longint'(r_pa1[k]) - longint'(r_pb1[k]), UNIT_FRAC));
            r_n2[k]   <= N_W'(rshr(longint'(r_pa2[k]) - longint'(r_pb2[k]), UNIT_FRAC));
            r_u1_2[k] <= r_u1_1[k];

            r_ma[k]   <= PW2'(r_n1[K1]) * PW2'(r_u1_2[K2]);
            r_mb[k]   <= PW2'(r_n1[K2]) * PW2'(r_u1_2[K1]);
            r_n1_3[k] <= r_n1[k];
            r_n2_3[k] <= r_n2[k];

            r_m[k]    <= M_W'(rshr(longint'(r_ma[k]) - longint'(r_mb[k]), UNIT_FRAC));
            r_n1_4[k] <= r_n1_3[k];
            r_n2_4[k] <= r_n2_3[k];

            r_xp[k]   <= XPW'(r_n1_4[k]) * XPW'(r_n2_4[k]);
            r_yp[k]   <= YPW'(r_m[k]) * YPW'(r_n2_4[k]);
        end
    end

    always_ff @(posedge i_clk) begin
        r_x <= XY_W'(r_xp[0]) + XY_W'(r_xp[1]) + XY_W'(r_xp[2]);
        r_y <= XY_W'(r_yp[0]) + XY_W'(r_yp[1]) + XY_W'(r_yp[2]);
        r_dg[0] <= i_degen;
        for (int s = 1; s < 5; s++) begin
            r_dg[s] <= r_dg[s-1];
        end
        r_dg[5] <= r_dg[4] ||
                   ((r_xp[0] + r_xp[1] + r_xp[2] == '0) && (r_yp[0] + r_yp[1] + r_yp[2] == '0));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int s = 0; s < 6; s++) begin
                r_v[s] <= 1'b0;
            end
        end else begin
            r_v[0] <= i_valid;
            for (int s = 1; s < 6; s++) begin
                r_v[s] <= r_v[s-1];
            end
        end
    end

    assign o_x     = r_x;
    assign o_y     = r_y;
    assign o_degen = r_dg[5];
    assign o_valid = r_v[5];

endmodule

@@ hdl/dau_cordic.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dau_cordic
// atan2(y, x) in degrees: quadrant fold, power-of-two prescale, one
// vectoring rotation per stage, Q8.8 rounding and clamping, 0 if degenerate.
// ----------------------------------------------------------------------------
module dau_cordic #(
    parameter int STEPS = dau_pkg::CORDIC_STEPS_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    input  dau_pkg::t_xy  i_x,
    input  dau_pkg::t_xy  i_y,
    input  logic          i_degen,
    output logic          o_valid,
    output dau_pkg::t_result o_result
);
    import dau_pkg::*;

    typedef logic signed [CORDIC_W-1:0] t_cw;
    typedef logic signed [ACC_W-1:0]    t_acc;

    t_cw  p_x [NORM_STAGES+2];
    t_cw  p_y [NORM_STAGES+2];
    t_acc p_a [NORM_STAGES+2];
    logic p_d [NORM_STAGES+2];
    logic p_v [NORM_STAGES+2];

    t_cw  c_x [STEPS+1];
    t_cw  c_y [STEPS+1];
    t_acc c_a [STEPS+1];
    logic c_d [STEPS+1];
    logic c_v [STEPS+1];

    t_result r_res;
    logic    r_res_v;

    // quadrant fold so that x >= 0
    always_ff @(posedge i_clk) begin
        if (i_x < 0) begin
            if (i_y >= 0) begin
                p_x[0] <= CORDIC_W'(i_y);
                p_y[0] <= -CORDIC_W'(i_x);
                p_a[0] <= ACC_W'(DEG90_Q16);
            end else begin
                p_x[0] <= -CORDIC_W'(i_y);
                p_y[0] <= CORDIC_W'(i_x);
                p_a[0] <= -ACC_W'(DEG90_Q16);
            end
        end else begin
            p_x[0] <= CORDIC_W'(i_x);
            p_y[0] <= CORDIC_W'(i_y);
            p_a[0] <= '0;
        end
        p_d[0] <= i_degen;
    end

    // stages 1..NORM_STAGES: largest shift keeping both below 2^40,
    // last stage: one more doubling
    for (genvar g = 0; g <= NORM_STAGES; g++) begin : g_pre
        localparam int K = (g < NORM_STAGES) ? (1 << (NORM_STAGES - 1 - g)) : 1;
        localparam int E = (g < NORM_STAGES) ? NORM_EXP - K : NORM_EXP;
        t_cw  ay;
        logic fit;
        assign ay  = (p_y[g] < 0) ? -p_y[g] : p_y[g];
        assign fit = (p_x[g] < (t_cw'(1) <<< E)) && (ay < (t_cw'(1) <<< E));
        always_ff @(posedge i_clk) begin
            p_x[g+1] <= fit ? (p_x[g] <<< K) : p_x[g];
            p_y[g+1] <= fit ? (p_y[g] <<< K) : p_y[g];
            p_a[g+1] <= p_a[g];
            p_d[g+1] <= p_d[g];
        end
    end

    assign c_x[0] = p_x[NORM_STAGES+1];
    assign c_y[0] = p_y[NORM_STAGES+1];
    assign c_a[0] = p_a[NORM_STAGES+1];
    assign c_d[0] = p_d[NORM_STAGES+1];
    assign c_v[0] = p_v[NORM_STAGES+1];

    for (genvar i = 0; i < STEPS; i++) begin : g_rot
        t_cw xs, ys;
        assign xs = c_x[i] >>> i;
        assign ys = c_y[i] >>> i;
        always_ff @(posedge i_clk) begin
            if (c_y[i] >= 0) begin
                c_x[i+1] <= c_x[i] + ys;
                c_y[i+1] <= c_y[i] - xs;
                c_a[i+1] <= c_a[i] + atan_q16(i);
            end else begin
                c_x[i+1] <= c_x[i] - ys;
                c_y[i+1] <= c_y[i] + xs;
                c_a[i+1] <= c_a[i] - atan_q16(i);
            end
            c_d[i+1] <= c_d[i];
        end
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                c_v[i+1] <= 1'b0;
            end else begin
                c_v[i+1] <= c_v[i];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int s = 0; s < NORM_STAGES + 2; s++) begin
                p_v[s] <= 1'b0;
            end
            r_res_v <= 1'b0;
        end else begin
            p_v[0] <= i_valid;
            for (int s = 1; s < NORM_STAGES + 2; s++) begin
                p_v[s] <= p_v[s-1];
            end
            r_res_v <= c_v[STEPS];
        end
    end

    always_ff @(posedge i_clk) begin
        longint a;
        a = rshr(longint'(c_a[STEPS]), ROUND_SHIFT);
        if (a > ANG_MAX) begin
            a = ANG_MAX;
        end
        if (a < -ANG_MAX) begin
            a = -ANG_MAX;
        end
        r_res.torsion_deg <= c_d[STEPS] ? '0 : ANG_W'(a);
        r_res.degenerate  <= c_d[STEPS];
    end

    assign o_result = r_res;
    assign o_valid  = r_res_v;

endmodule

@@ hdl/dihedral_angle_unit_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dihedral_angle_unit_core
// Torsion angle of four points about the b-c bond, Q8.8 degrees.
// ----------------------------------------------------------------------------
//  channel | ports                         | beat taken when
//  --------+-------------------------------+---------------------
//  item in | start, busy, i_item           | start && !busy
//  result  | o_done, o_result              | o_done (one cycle)
//
//  Fully pipelined: one beat per cycle, busy stays low.
//  Pipeline: input register, the bond normalisers with their bit-per-stage
//  square root and divider, the geometry stages, then the CORDIC with
//  one stage per rotation.
//  Reset clears the valid bits only; results come out in input order and
//  the receiver takes each one in the cycle it is shown.
// ----------------------------------------------------------------------------
module dihedral_angle_unit_core #(
    parameter int CORDIC_STEPS = dau_pkg::CORDIC_STEPS_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             start,
    output logic             busy,
    input  dau_pkg::t_item   i_item,
    output logic             o_done,
    output dau_pkg::t_result o_result
);
    import dau_pkg::*;

    localparam int LAT = 1 + NORM_LAT + GEOM_LAT + CORDIC_FIX_LAT + CORDIC_STEPS;

    t_item  r_in;
    logic   r_in_v;
    t_coord pa [3], pb [3], pc [3], pd [3];
    t_unit  u0 [3], u1 [3], u2 [3];
    logic   nv0, nv1, nv2, z0, z1, z2;
    logic   g_v, g_dg;
    t_xy    g_x, g_y;

    assign busy = 1'b0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_v <= 1'b0;
        end else begin
            r_in_v <= start && !busy;
        end
    end

    always_ff @(posedge i_clk) begin
        r_in <= i_item;
    end

    assign pa = '{r_in.a_x, r_in.a_y, r_in.a_z};
    assign pb = '{r_in.b_x, r_in.b_y, r_in.b_z};
    assign pc = '{r_in.c_x, r_in.c_y, r_in.c_z};
    assign pd = '{r_in.d_x, r_in.d_y, r_in.d_z};

    dau_norm u_norm_ab (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(r_in_v),
        .i_p0(pa), .i_p1(pb), .o_valid(nv0), .o_u(u0), .o_zero(z0)
    );
    dau_norm u_norm_bc (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(r_in_v),
        .i_p0(pb), .i_p1(pc), .o_valid(nv1), .o_u(u1), .o_zero(z1)
    );
    dau_norm u_norm_cd (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(r_in_v),
        .i_p0(pc), .i_p1(pd), .o_valid(nv2), .o_u(u2), .o_zero(z2)
    );

    dau_geom u_geom (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(nv0 && nv1 && nv2),
        .i_u0(u0), .i_u1(u1), .i_u2(u2), .i_degen(z0 || z1 || z2),
        .o_valid(g_v), .o_x(g_x), .o_y(g_y), .o_degen(g_dg)
    );

    dau_cordic #(
        .STEPS(CORDIC_STEPS)
    ) u_cordic (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(g_v),
        .i_x(g_x), .i_y(g_y), .i_degen(g_dg),
        .o_valid(o_done), .o_result(o_result)
    );

    a_lat_hit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |-> ##LAT o_done)
        else $error("accepted beat not delivered after pipeline latency");

    a_lat_none: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(start && !busy) |-> ##LAT !o_done)
        else $error("result beat without matching input beat");

    a_degen_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_result.degenerate) |-> (o_result.torsion_deg == '0))
        else $error("degenerate result with nonzero angle");

    a_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> ((o_result.torsion_deg <= ANG_W'(ANG_MAX)) &&
                    (o_result.torsion_deg >= -ANG_W'(ANG_MAX))))
        else $error("angle outside +/-180 degrees");

endmodule

@@ bench/torsion_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// torsion_checker
// Watches item and result beats of the dihedral angle unit, computes the
// expected torsion angle and degenerate flag of each accepted item, and
// compares every result beat with the oldest pending prediction.
// ----------------------------------------------------------------------------
module torsion_checker (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             start,
    input  logic             busy,
    input  dau_pkg::t_item   i_item,
    input  logic             o_done,
    input  dau_pkg::t_result o_result,
    output int               o_errors,
    output int               o_pending,
    output int               o_results,
    output int               o_degen
);
    import dau_pkg::*;

    localparam int STEPS = CORDIC_STEPS_DEF;

    t_result angle_q[$];

    function automatic longint floor_shr(longint v, int k);
        return v >>> k;
    endfunction

    function automatic longint round_shr(longint v, int k);
        longint half;
        half = longint'(1) << (k - 1);
        if (v >= 0) return (v + half) >>> k;
        return -((-v + half) >>> k);
    endfunction

    function automatic longint mag(longint v);
        return v < 0 ? -v : v;
    endfunction

    function automatic longint int_sqrt(longint n);
        longint r, b;
        r = 0;
        b = longint'(1) << 62;
        while (b > n) b = b >>> 2;
        while (b != 0) begin
            if (n >= r + b) begin
                n = n - (r + b);
                r = (r >>> 1) + b;
            end else begin
                r = r >>> 1;
            end
            b = b >>> 2;
        end
        return r;
    endfunction

    function automatic bit make_unit(input longint v[3], output longint u[3]);
        longint w[3];
        longint mx, sq, len, q;
        w = v;
        u = '{0, 0, 0};
        if (w[0] == 0 && w[1] == 0 && w[2] == 0) return 0;
        forever begin
            mx = mag(w[0]);
            if (mag(w[1]) > mx) mx = mag(w[1]);
            if (mag(w[2]) > mx) mx = mag(w[2]);
            if (mx < (longint'(1) << 30)) break;
            for (int i = 0; i < 3; i++) w[i] = floor_shr(w[i], 1);
        end
        sq = 0;
        for (int i = 0; i < 3; i++) sq += w[i] * w[i];
        len = int_sqrt(sq);
        if (len == 0) return 0;
        for (int i = 0; i < 3; i++) begin
            q = ((mag(w[i]) << UNIT_FRAC) + len / 2) / len;
            u[i] = w[i] < 0 ? -q : q;
        end
        return 1;
    endfunction

    function automatic void cross14(input longint p[3], input longint q[3],
                                    output longint r[3]);
        r[0] = round_shr(p[1] * q[2] - p[2] * q[1], UNIT_FRAC);
        r[1] = round_shr(p[2] * q[0] - p[0] * q[2], UNIT_FRAC);
        r[2] = round_shr(p[0] * q[1] - p[1] * q[0], UNIT_FRAC);
    endfunction

    function automatic longint atan2_deg(longint x, longint y);
        longint acc, t, xs, ys;
        acc = 0;
        if (x < 0) begin
            if (y >= 0) begin
                t = x; x = y; y = -t; acc = longint'(90) << 16;
            end else begin
                t = x; x = -y; y = t; acc = -(longint'(90) << 16);
            end
        end
        while (mag(x) < (longint'(1) << 40) && mag(y) < (longint'(1) << 40)) begin
            x = x * 2;
            y = y * 2;
        end
        for (int i = 0; i < STEPS && i < 32; i++) begin
            xs = x >>> i;
            ys = y >>> i;
            if (y >= 0) begin
                x = x + ys; y = y - xs; acc += longint'(ATAN_TAB[i]);
            end else begin
                x = x - ys; y = y + xs; acc -= longint'(ATAN_TAB[i]);
            end
        end
        return acc;
    endfunction

    function automatic t_result torsion_of(t_item it);
        longint p[4][3];
        longint v[3], u0[3], u1[3], u2[3], uu[3], n1[3], n2[3], m[3];
        longint x, y, ang;
        bit degen;
        t_result r;
        p[0] = '{it.a_x, it.a_y, it.a_z};
        p[1] = '{it.b_x, it.b_y, it.b_z};
        p[2] = '{it.c_x, it.c_y, it.c_z};
        p[3] = '{it.d_x, it.d_y, it.d_z};
        degen = 0;
        ang = 0;
        for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 3; j++) v[j] = p[i+1][j] - p[i][j];
            if (!make_unit(v, uu)) degen = 1;
            if (i == 0) u0 = uu; else if (i == 1) u1 = uu; else u2 = uu;
        end
        if (!degen) begin
            cross14(u0, u1, n1);
            cross14(u1, u2, n2);
            cross14(n1, u1, m);
            x = n1[0] * n2[0] + n1[1] * n2[1] + n1[2] * n2[2];
            y = m[0] * n2[0] + m[1] * n2[1] + m[2] * n2[2];
            if (x == 0 && y == 0) begin
                degen = 1;
            end else begin
                ang = round_shr(atan2_deg(x, y), ROUND_SHIFT);
                if (ang > ANG_MAX) ang = ANG_MAX;
                if (ang < -ANG_MAX) ang = -ANG_MAX;
            end
        end
        r.torsion_deg = ANG_W'(ang);
        r.degenerate = degen;
        return r;
    endfunction

    assign o_pending = angle_q.size();

    always_ff @(posedge i_clk) begin
        t_result want;
        int      bad;
        bad = 0;
        if (!i_rst_n) begin
            o_errors <= 0;
            o_results <= 0;
            o_degen <= 0;
        end else begin
            if (start && !busy) angle_q.push_back(torsion_of(i_item));
            if (o_done) begin
                o_results <= o_results + 1;
                if (o_result.degenerate) o_degen <= o_degen + 1;
                if (angle_q.size() == 0) begin
                    $error("result beat with no pending item");
                    bad = bad + 1;
                end else begin
                    want = angle_q.pop_front();
                    if (want.torsion_deg !== o_result.torsion_deg) begin
                        $error("torsion_deg expected %0d actual %0d",
                               want.torsion_deg, o_result.torsion_deg);
                        bad = bad + 1;
                    end
                    if (want.degenerate !== o_result.degenerate) begin
                        $error("degenerate expected %0b actual %0b",
                               want.degenerate, o_result.degenerate);
                        bad = bad + 1;
                    end
                end
            end
            o_errors <= o_errors + bad;
        end
    end
endmodule

@@ bench/tb_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Stimulus and verdict for the dihedral angle unit: directed corner points,
// then random geometry with idle gaps; the checker scores every result.
// ----------------------------------------------------------------------------
module tb_top;
    import dau_pkg::*;

    localparam int N_RANDOM = 1430;
    localparam int DRAIN    = 150;
    localparam longint LIMIT = 400000;

    logic    i_clk = 0;
    logic    i_rst_n = 0;
    logic    start = 0;
    logic    busy;
    t_item   i_item = '0;
    logic    o_done;
    t_result o_result;
    int      errors, pending, results, degens;
    longint  cycles = 0;

    always begin
        #2 i_clk = 1;
        #2 i_clk = 0;
    end

    dihedral_angle_unit_core dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy),
        .i_item(i_item), .o_done(o_done), .o_result(o_result)
    );

    torsion_checker chk (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy),
        .i_item(i_item), .o_done(o_done), .o_result(o_result),
        .o_errors(errors), .o_pending(pending), .o_results(results),
        .o_degen(degens)
    );

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    function automatic t_coord rnd_coord(int mode);
        case (mode)
            0: return t_coord'($urandom);
            1: return t_coord'($urandom_range(0, 2047) - 1024);
            default: return t_coord'($urandom_range(0, 63) - 32);
        endcase
    endfunction

    function automatic t_item rnd_item();
        t_item it;
        int mode;
        mode = $urandom_range(0, 9) < 3 ? 0 : ($urandom_range(0, 1) ? 1 : 2);
        it = {rnd_coord(mode), rnd_coord(mode), rnd_coord(mode),
              rnd_coord(mode), rnd_coord(mode), rnd_coord(mode),
              rnd_coord(mode), rnd_coord(mode), rnd_coord(mode),
              rnd_coord(mode), rnd_coord(mode), rnd_coord(mode)};
        case ($urandom_range(0, 19))
            0: {it.b_x, it.b_y, it.b_z} = {it.a_x, it.a_y, it.a_z};
            1: {it.c_x, it.c_y, it.c_z} = {it.b_x, it.b_y, it.b_z};
            2: {it.d_x, it.d_y, it.d_z} = {it.c_x, it.c_y, it.c_z};
            3: begin
                it.c_x = it.b_x + (it.b_x - it.a_x) / 2;
                it.c_y = it.b_y + (it.b_y - it.a_y) / 2;
                it.c_z = it.b_z + (it.b_z - it.a_z) / 2;
            end
            default: ;
        endcase
        return it;
    endfunction

    function automatic t_item pts(int ax, int ay, int az, int bx, int by, int bz,
                                  int cx, int cy, int cz, int dx, int dy, int dz);
        return {t_coord'(ax), t_coord'(ay), t_coord'(az), t_coord'(bx),
                t_coord'(by), t_coord'(bz), t_coord'(cx), t_coord'(cy),
                t_coord'(cz), t_coord'(dx), t_coord'(dy), t_coord'(dz)};
    endfunction

    // start stays high across back-to-back beats; dropped only for gaps
    task automatic send_beat(t_item it, int gap);
        if (gap > 0) begin
            start <= 0;
            repeat (gap) @(posedge i_clk);
        end
        start <= 1;
        i_item <= it;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
    endtask

    task automatic send_run(t_item it);
        int gap;
        gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 15);
        send_beat(it, gap);
    endtask

    initial begin
        t_item dir[$];
        int burst;
        bit paused;
        paused = 0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);

        dir.push_back(pts(256, 0, 0, 0, 0, 0, 0, 256, 0, 256, 256, 256));
        dir.push_back(pts(256, 0, 0, 0, 0, 0, 0, 256, 0, -256, 256, 0));
        dir.push_back(pts(256, 0, 0, 0, 0, 0, 0, 256, 0, 256, 256, 0));
        dir.push_back(pts(256, 0, 0, 0, 0, 0, 0, 256, 0, 0, 256, -256));
        dir.push_back(pts(256, 0, 0, 0, 0, 0, 0, 256, 0, 256, 256, 1));
        dir.push_back(pts(256, 0, 0, 0, 0, 0, 0, 256, 0, 256, 256, -1));
        dir.push_back(pts(5, 5, 5, 5, 5, 5, 0, 256, 0, 1, 2, 3));
        dir.push_back(pts(0, 0, 0, 256, 0, 0, 256, 0, 0, 1, 2, 3));
        dir.push_back(pts(0, 0, 0, 256, 0, 0, 512, 512, 0, 512, 512, 0));
        dir.push_back(pts(0, 0, 0, 256, 0, 0, 512, 0, 0, 9, 9, 9));
        dir.push_back(pts(-32768, -32768, -32768, 32767, 32767, 32767,
                          -32768, 32767, -32768, 32767, -32768, 32767));
        dir.push_back(pts(32767, -32768, 0, -32768, 32767, 0,
                          32767, 32767, -32768, -32768, -32768, 32767));
        dir.push_back(pts(-1, -1, -1, 0, 0, 0, 1, 0, 0, 1, 1, 0));
        dir.push_back(pts(0, 0, 0, 1, 0, 0, 1, 1, 0, 1, 1, 1));
        dir.push_back(pts(-1, 0, 0, 0, 0, 0, 0, 1, 0, 1, 1, 0));
        dir.push_back('1);
        dir.push_back(pts(0, 0, 0, -1, -1, -1, 0, 0, 0, 1, 1, 1));
        foreach (dir[i]) send_run(dir[i]);

        for (int n = 0; n < N_RANDOM; n++) begin
            if (!paused && n >= N_RANDOM / 2) begin
                paused = 1;
                start <= 0;
                @(posedge i_clk);
                while (pending != 0) @(posedge i_clk);
            end
            if ($urandom_range(0, 7) == 0) begin
                burst = $urandom_range(5, 40);
                for (int k = 0; k < burst && n < N_RANDOM; k++, n++)
                    send_beat(rnd_item(), 0);
            end
            send_run(rnd_item());
        end

        start <= 0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (DRAIN) @(posedge i_clk);
        $display("Ran %0d torsion results, %0d flagged degenerate, mixed gaps.",
                 results, degens);
        if (errors == 0 && pending == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end
endmodule
